// ===== sv/wsab_pkg.sv =====
// Shared types and constants for the windowed spike-age buffers.
// No dependencies.
package wsab_pkg;

  localparam int NumBuffersDef = 4;
  localparam int DepthDef      = 16;
  localparam int TimeBits      = 32;
  localparam int ConnBits      = 16;
  localparam int NumRegs       = 4;
  localparam int AddrBits      = 4;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_ELAPSE = 2'd1,
    MODE_COUNT  = 2'd2,
    MODE_ENTRY  = 2'd3
  } mode_e;

  typedef struct packed {
    logic latch;
    logic add;
    logic el_init;
    logic el_rd;
    logic el_wr;
    logic el_next;
    logic q_rd;
    logic q_out;
  } cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  ent_avail;
    logic  buf_last;
  } stat_t;

endpackage

// ===== sv/windowed_spike_age_buffers_top.sv =====
// Top level: window registers, sequencer and datapath of the spike-age buffers.
// An add decodes then writes; a count query decodes then outputs; an entry query
// decodes, reads, outputs; the elapse pass walks the entry store one entry at a time.
// One item in flight; the result beat is a one-cycle done_o strobe, no stall.
// Asynchronous active-low reset empties every buffer and clears the windows.
// Depends on wsab_pkg, wsab_regs, wsab_ctrl, wsab_dp.
module windowed_spike_age_buffers_top #(
  parameter int NumBuffers = wsab_pkg::NumBuffersDef,
  parameter int Depth      = wsab_pkg::DepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    mode_i,
  input  logic [1:0]                    buffer_sel_i,
  input  logic [15:0]                   conn_id_i,
  input  logic [31:0]                   elapsed_i,
  input  logic [3:0]                    position_i,
  output logic                          done_o,
  output logic [4:0]                    spike_count_o,
  output logic [31:0]                   age_out_o,
  output logic [15:0]                   conn_out_o,
  output logic                          found_o,
  output logic                          dropped_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wsab_pkg::AddrBits-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import wsab_pkg::*;

  logic [TimeBits-1:0] win [NumBuffers];
  cmd_t  cmd;
  stat_t stat;

  wsab_regs #(.NumBuffers(NumBuffers)) u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .win_o(win)
  );

  wsab_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .stat_i(stat), .cmd_o(cmd), .busy_o
  );

  wsab_dp #(.NumBuffers(NumBuffers), .Depth(Depth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .mode_i, .buffer_sel_i, .conn_id_i, .elapsed_i, .position_i,
    .win_i(win), .done_o, .spike_count_o, .age_out_o, .conn_out_o,
    .found_o, .dropped_o
  );

endmodule

// ===== sv/wsab_regs.sv =====
// APB window registers of the spike-age buffers.
// Depends on wsab_pkg.
module wsab_regs #(
  parameter int NumBuffers = wsab_pkg::NumBuffersDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wsab_pkg::AddrBits-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [wsab_pkg::TimeBits-1:0] win_o [NumBuffers]
);
  import wsab_pkg::*;

  logic [31:0] win_q [NumRegs];
  logic [1:0]  idx;

  assign idx    = paddr[3:2];
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) win_q[i] <= '0;
    end else if (psel && penable && pwrite && (32'(idx) < 32'(NumBuffers))) begin
      win_q[idx] <= pwdata;
    end
  end

  always_comb begin
    prdata = (32'(idx) < 32'(NumBuffers)) ? win_q[idx] : '0;
  end

  always_comb begin
    for (int b = 0; b < NumBuffers; b++) begin
      win_o[b] = (b < NumRegs) ? TimeBits'(win_q[b % NumRegs]) : '0;
    end
  end

endmodule

// ===== sv/wsab_ctrl.sv =====
// Sequencer for the spike-age buffers: decodes items, walks elapse passes.
// Depends on wsab_pkg.
module wsab_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  wsab_pkg::stat_t       stat_i,
  output wsab_pkg::cmd_t        cmd_o,
  output logic                  busy_o
);
  import wsab_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DEC  = 9'b000000010,
    S_ADD  = 9'b000000100,
    S_QRD  = 9'b000001000,
    S_OUT  = 9'b000010000,
    S_ECHK = 9'b000100000,
    S_ERD  = 9'b001000000,
    S_EWR  = 9'b010000000,
    S_ENXT = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DEC;
        end
      end
      S_DEC: begin
        unique case (stat_i.mode)
          MODE_ADD:    state_d = S_ADD;
          MODE_ELAPSE: begin
            cmd_o.el_init = 1'b1;
            state_d       = S_ECHK;
          end
          MODE_COUNT:  state_d = S_OUT;
          MODE_ENTRY:  state_d = S_QRD;
          default:     state_d = S_IDLE;
        endcase
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = S_IDLE;
      end
      S_QRD: begin
        cmd_o.q_rd = 1'b1;
        state_d    = S_OUT;
      end
      S_OUT: begin
        cmd_o.q_out = 1'b1;
        state_d     = S_IDLE;
      end
      S_ECHK: begin
        state_d = stat_i.ent_avail ? S_ERD : S_ENXT;
      end
      S_ERD: begin
        cmd_o.el_rd = 1'b1;
        state_d     = S_EWR;
      end
      S_EWR: begin
        cmd_o.el_wr = 1'b1;
        state_d     = S_ECHK;
      end
      S_ENXT: begin
        cmd_o.el_next = 1'b1;
        state_d       = stat_i.buf_last ? S_OUT : S_ECHK;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== sv/wsab_dp.sv =====
// Datapath of the spike-age buffers: entry stores, head/fill state, results.
// Depends on wsab_pkg.
module wsab_dp #(
  parameter int NumBuffers = wsab_pkg::NumBuffersDef,
  parameter int Depth      = wsab_pkg::DepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wsab_pkg::cmd_t                cmd_i,
  output wsab_pkg::stat_t               stat_o,
  input  logic [1:0]                    mode_i,
  input  logic [1:0]                    buffer_sel_i,
  input  logic [15:0]                   conn_id_i,
  input  logic [31:0]                   elapsed_i,
  input  logic [3:0]                    position_i,
  input  logic [wsab_pkg::TimeBits-1:0] win_i [NumBuffers],
  output logic                          done_o,
  output logic [4:0]                    spike_count_o,
  output logic [31:0]                   age_out_o,
  output logic [15:0]                   conn_out_o,
  output logic                          found_o,
  output logic                          dropped_o
);
  import wsab_pkg::*;

  localparam int SW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam int BW = (NumBuffers > 1) ? $clog2(NumBuffers) : 1;
  localparam int NE = NumBuffers * Depth;
  localparam int AW = (NE > 1) ? $clog2(NE) : 1;

  function automatic logic [SW-1:0] wrap(input logic [SW-1:0] h, input logic [CW-1:0] k);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(k);
    if (s >= (CW+1)'(Depth)) s = s - (CW+1)'(Depth);
    return SW'(s);
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [BW-1:0] b, input logic [SW-1:0] s);
    return AW'(AW'(b) * AW'(Depth) + AW'(s));
  endfunction

  logic [TimeBits-1:0] age_mem  [NE];
  logic [ConnBits-1:0] conn_mem [NE];
  logic [TimeBits-1:0] age_rd_q;
  logic [ConnBits-1:0] conn_rd_q;

  logic [SW-1:0] head_q [NumBuffers];
  logic [CW-1:0] fill_q [NumBuffers];

  mode_e         mode_q;
  logic [1:0]    sel_q;
  logic [15:0]   conn_q;
  logic [31:0]   dt_q;
  logic [3:0]    pos_q;

  logic [BW-1:0] eb_q;
  logic [CW-1:0] k_q;
  logic [CW-1:0] pop_q;
  logic          popping_q;

  logic          done_q;
  logic [4:0]    cnt_q;
  logic [31:0]   age_o_q;
  logic [15:0]   conn_o_q;
  logic          found_q;
  logic          drop_q;

  logic          sel_ok;
  logic [BW-1:0] sb;
  logic [CW-1:0] sfill;
  logic          full;
  logic          q_found;
  logic [AW-1:0] el_addr;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] add_addr;
  logic [TimeBits:0] sum;
  logic [TimeBits-1:0] new_age;

  assign sel_ok   = 32'(sel_q) < 32'(NumBuffers);
  assign sb       = BW'(sel_q);
  assign sfill    = sel_ok ? fill_q[sb] : '0;
  assign full     = (sfill == CW'(Depth));
  assign q_found  = sel_ok && ((CW+4)'(pos_q) < (CW+4)'(sfill));
  assign el_addr  = addr_of(eb_q, wrap(head_q[eb_q], k_q));
  assign add_addr = addr_of(sb, wrap(head_q[sb], sfill));
  assign rd_addr  = cmd_i.q_rd ? addr_of(sb, wrap(head_q[sb], CW'(pos_q))) : el_addr;
  assign sum      = (TimeBits+1)'(age_rd_q) + (TimeBits+1)'(dt_q);
  assign new_age  = sum[TimeBits] ? '1 : sum[TimeBits-1:0];

  assign stat_o.mode      = mode_q;
  assign stat_o.ent_avail = k_q < fill_q[eb_q];
  assign stat_o.buf_last  = (32'(eb_q) == 32'(NumBuffers - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.el_rd || cmd_i.q_rd) begin
      age_rd_q  <= age_mem[rd_addr];
      conn_rd_q <= conn_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add && sel_ok && !full) begin
      age_mem[add_addr]  <= '0;
      conn_mem[add_addr] <= ConnBits'(conn_q);
    end else if (cmd_i.el_wr) begin
      age_mem[el_addr] <= new_age;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q <= mode_e'(mode_i);
      sel_q  <= buffer_sel_i;
      conn_q <= conn_id_i;
      dt_q   <= elapsed_i;
      pos_q  <= position_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NumBuffers; b++) begin
        head_q[b] <= '0;
        fill_q[b] <= '0;
      end
      eb_q      <= '0;
      k_q       <= '0;
      pop_q     <= '0;
      popping_q <= 1'b0;
    end else begin
      if (cmd_i.add && sel_ok && !full) fill_q[sb] <= fill_q[sb] + 1'b1;
      if (cmd_i.el_init) begin
        eb_q      <= '0;
        k_q       <= '0;
        pop_q     <= '0;
        popping_q <= 1'b1;
      end
      if (cmd_i.el_wr) begin
        k_q <= k_q + 1'b1;
        if (popping_q && (new_age > win_i[eb_q])) pop_q <= pop_q + 1'b1;
        else popping_q <= 1'b0;
      end
      if (cmd_i.el_next) begin
        head_q[eb_q] <= wrap(head_q[eb_q], pop_q);
        fill_q[eb_q] <= fill_q[eb_q] - pop_q;
        eb_q         <= eb_q + 1'b1;
        k_q          <= '0;
        pop_q        <= '0;
        popping_q    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= cmd_i.add || cmd_i.q_out;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add) begin
      cnt_q    <= 5'((sel_ok && !full) ? sfill + 1'b1 : sfill);
      age_o_q  <= '0;
      conn_o_q <= '0;
      found_q  <= 1'b0;
      drop_q   <= !sel_ok || full;
    end else if (cmd_i.q_out) begin
      cnt_q <= 5'(sfill);
      drop_q <= 1'b0;
      if (mode_q == MODE_ENTRY && q_found) begin
        age_o_q  <= 32'(age_rd_q);
        conn_o_q <= 16'(conn_rd_q);
        found_q  <= 1'b1;
      end else begin
        age_o_q  <= '0;
        conn_o_q <= '0;
        found_q  <= 1'b0;
      end
    end
  end

  assign done_o        = done_q;
  assign spike_count_o = cnt_q;
  assign age_out_o     = age_o_q;
  assign conn_out_o    = conn_o_q;
  assign found_o       = found_q;
  assign dropped_o     = drop_q;

endmodule

// ===== tb/sv/wsab_checker.sv =====
// Checker for the windowed spike-age buffers: watches accepted items, window
// writes and result beats, predicts each result and compares it with the observed beat.
// Depends on wsab_pkg.
module wsab_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  mode_i,
  input  logic [1:0]  buffer_sel_i,
  input  logic [15:0] conn_id_i,
  input  logic [31:0] elapsed_i,
  input  logic [3:0]  position_i,
  input  logic        done_i,
  input  logic [4:0]  spike_count_i,
  input  logic [31:0] age_out_i,
  input  logic [15:0] conn_out_i,
  input  logic        found_i,
  input  logic        dropped_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending,
  output int          beats_seen
);
  import wsab_pkg::*;

  localparam int NB = 4;
  localparam int DP = 16;

  typedef struct packed {
    logic [4:0]  count;
    logic [31:0] age;
    logic [15:0] conn;
    logic        found;
    logic        dropped;
  } spike_res_t;

  logic [31:0] win      [NB];
  logic [31:0] ages     [NB][DP];
  logic [15:0] conns    [NB][DP];
  logic [3:0]  head     [NB];
  logic [4:0]  fill     [NB];
  spike_res_t  expected_q[$];

  function automatic spike_res_t predict_spike(mode_e m, int b, logic [15:0] cid,
                                               logic [31:0] dt, int pos);
    spike_res_t r;
    logic [32:0] sum;
    int s;
    r = '0;
    case (m)
      MODE_ADD: begin
        if (fill[b] >= DP) r.dropped = 1'b1;
        else begin
          s = (head[b] + fill[b]) % DP;
          ages[b][s]  = '0;
          conns[b][s] = cid;
          fill[b]++;
        end
      end
      MODE_ELAPSE: begin
        for (int i = 0; i < NB; i++) begin
          for (int k = 0; k < fill[i]; k++) begin
            s = (head[i] + k) % DP;
            sum = {1'b0, ages[i][s]} + {1'b0, dt};
            ages[i][s] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          end
          while (fill[i] > 0 && ages[i][head[i]] > win[i]) begin
            head[i] = head[i] + 4'd1;
            fill[i]--;
          end
        end
      end
      MODE_ENTRY: begin
        if (pos < fill[b]) begin
          s = (head[b] + pos) % DP;
          r.age   = ages[b][s];
          r.conn  = conns[b][s];
          r.found = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = fill[b];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    spike_res_t e, a;
    if (!rst_ni) begin
      for (int i = 0; i < NB; i++) begin
        win[i] = '0; head[i] = '0; fill[i] = '0;
      end
      fail_count <= 0;
      beats_seen <= 0;
      pending    <= 0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && paddr[3:2] < NB) win[paddr[3:2]] = pwdata;
      if (done_i) begin
        beats_seen <= beats_seen + 1;
        a = '{spike_count_i, age_out_i, conn_out_i, found_i, dropped_i};
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat %p", a);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e !== a) begin
            if (fail_count < 10) $display("mismatch: expected %p, got %p", e, a);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start_i && !busy_i)
        expected_q.push_back(predict_spike(mode_e'(mode_i), buffer_sel_i, conn_id_i,
                                           elapsed_i, position_i));
      pending <= expected_q.size();
    end
  end
endmodule

// ===== tb/sv/tb_windowed_spike_age_buffers_top.sv =====
// Testbench top for the windowed spike-age buffers: directed and random spike,
// elapse and query items, window writes over APB, verdict. Depends on the DUT,
// wsab_pkg and wsab_checker.
module tb_windowed_spike_age_buffers_top;
  import wsab_pkg::*;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic start_i = 1'b0, busy_o, done_o, found_o, dropped_o, pready;
  logic [1:0] mode_i = '0, buffer_sel_i = '0;
  logic [15:0] conn_id_i = '0, conn_out_o;
  logic [31:0] elapsed_i = '0, age_out_o, prdata, pwdata = '0;
  logic [3:0] position_i = '0, paddr = '0;
  logic [4:0] spike_count_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  int fail_count, pending, beats_seen, items_sent, idle_cycles;
  bit quiet;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  windowed_spike_age_buffers_top dut (.*);

  wsab_checker chk (.clk_i, .rst_ni, .start_i, .busy_i(busy_o), .mode_i, .buffer_sel_i,
    .conn_id_i, .elapsed_i, .position_i, .done_i(done_o), .spike_count_i(spike_count_o),
    .age_out_i(age_out_o), .conn_out_i(conn_out_o), .found_i(found_o),
    .dropped_i(dropped_o), .psel, .penable, .pwrite, .paddr, .pwdata, .fail_count,
    .pending, .beats_seen);

  // watchdog: cycles with no item accepted and no result beat
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_window(int idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 4'(idx * 4); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0 || busy_o) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic send_item(mode_e m, int b, logic [15:0] cid, logic [31:0] dt, int pos);
    if (!quiet) while ($urandom_range(99) < 10) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1; mode_i <= m; buffer_sel_i <= 2'(b);
    conn_id_i <= cid; elapsed_i <= dt; position_i <= 4'(pos);
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic random_windows();
    for (int i = 0; i < 4; i++)
      case ($urandom_range(3))
        0: write_window(i, 32'h0);
        1: write_window(i, 32'hFFFF_FFFF);
        2: write_window(i, $urandom_range(32'h0400_0000));
        default: write_window(i, $urandom);
      endcase
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_window(0, 32'h0);
    write_window(1, 32'hFFFF_FFFF);
    write_window(2, 32'h0100_0000);
    write_window(3, 32'h8000_0000);
    // directed: fill to overflow, extremes, queries past end, saturation
    for (int k = 0; k < 17; k++) send_item(MODE_ADD, 1, k[0] ? 16'hFFFF : 16'h0, 0, 0);
    send_item(MODE_ENTRY, 1, 0, 0, 15);
    send_item(MODE_ADD, 2, 16'hA5A5, 0, 0);
    send_item(MODE_ELAPSE, 0, 0, 32'h00FF_FFFF, 0);
    send_item(MODE_ENTRY, 2, 0, 0, 0);
    send_item(MODE_ELAPSE, 3, 0, 32'hFFFF_FFFF, 0);
    send_item(MODE_ELAPSE, 0, 0, 32'hFFFF_FFFF, 0);
    send_item(MODE_ENTRY, 1, 0, 0, 0);
    send_item(MODE_COUNT, 2, 0, 0, 0);
    send_item(MODE_ENTRY, 3, 0, 0, 15);
    start_i <= 1'b0;
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      random_windows();
      quiet = (ph == 2);
      for (int n = 0; n < 225; n++) begin
        case ($urandom_range(9))
          0, 1, 2, 3: send_item(MODE_ADD, $urandom_range(3), $urandom, 0, 0);
          4: send_item(MODE_ELAPSE, $urandom_range(3), 0,
                       $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0200_0000), 0);
          5: send_item(MODE_COUNT, $urandom_range(3), $urandom, $urandom, $urandom);
          default: send_item(MODE_ENTRY, $urandom_range(3), $urandom, $urandom,
                             $urandom_range(15));
        endcase
      end
      start_i <= 1'b0;
      drain();
    end
    quiet = 0;
    $display("Sent %0d items over seven window settings; %0d result beats checked.",
             items_sent, beats_seen);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
